// File: rtl/fcms_pkg.sv
// Package for the fixed-capacity multiset store: operation codes, port widths,
// default parameters and the controller/datapath command and status structs.
// No dependencies.
package fcms_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int FUNC_W      = 3;
  localparam int IN_VALUE_W  = 32;
  localparam int OUT_CNT_W   = 5;
  localparam int OUT_CNT_MAX = 31;

  localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_COUNT    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the input beat, reset scan state
    logic exec;      // add / clear / ignore, no scan needed
    logic scan;      // issue one read and compare per cycle
    logic rd_last;   // read the last live entry
    logic move;      // overwrite the hit slot with the last entry
    logic res_load;  // load the result register
  } fcms_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic is_remove;
  } fcms_sts_t;

endpackage

// File: rtl/fcms_ctrl.sv
// Controller state machine of the multiset store: sequences accept, scan,
// swap-on-remove and result hand-off. Depends on fcms_pkg.
module fcms_ctrl
  import fcms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  output logic              out_valid,
  input  logic              out_stall,
  output fcms_cmd_t         cmd,
  input  fcms_sts_t         sts
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_RDLAST = 3'd3;
  localparam logic [2:0] ST_MOVE   = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.load = 1'b1;
          case (in_func) inside
            FUNC_REMOVE, FUNC_COUNT, FUNC_CONTAINS: state_nxt = ST_SCAN;
            default:                                state_nxt = ST_EXEC;
          endcase
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = (sts.is_remove && sts.hit) ? ST_RDLAST : ST_FIN;
        end
      end
      ST_RDLAST: begin
        cmd.rd_last = 1'b1;
        state_nxt   = ST_MOVE;
      end
      ST_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // result register is free once the previous beat has gone
        if (!out_valid_r || !out_stall) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/fcms_dp.sv
// Datapath of the multiset store: entry memory, fill count, sequential
// compare scan, swap path and result register. Depends on fcms_pkg.
module fcms_dp
  import fcms_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [IN_VALUE_W-1:0] in_value,
  input  fcms_cmd_t             cmd,
  output fcms_sts_t             sts,
  output logic                  out_ok,
  output logic [OUT_CNT_W-1:0]  out_match_count,
  output logic [OUT_CNT_W-1:0]  out_size,
  output logic                  out_empty_res
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rdata_r;
  logic [VALUE_WIDTH-1:0] val_in;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [FUNC_W-1:0]      func_r;
  logic [CW-1:0]          fill_r, fill_nxt;
  logic [CW-1:0]          scan_idx_r;
  logic [CW-1:0]          cnt_r;
  logic [AW-1:0]          cmp_idx_r;
  logic [AW-1:0]          hit_idx_r;
  logic                   cmp_vld_r;
  logic                   hit_r;
  logic                   issue_vld;
  logic                   cmp_hit;
  logic                   has_room;
  logic                   add_we;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [AW-1:0]          raddr;
  logic [OUT_CNT_W-1:0]   cnt_sat;
  logic [OUT_CNT_W-1:0]   size_sat;
  logic                   res_ok_r;
  logic [OUT_CNT_W-1:0]   res_cnt_r;
  logic [OUT_CNT_W-1:0]   res_size_r;
  logic                   res_empty_r;

  generate
    if (VALUE_WIDTH <= IN_VALUE_W) begin : g_val_trunc
      assign val_in = in_value[VALUE_WIDTH-1:0];
    end else begin : g_val_ext
      assign val_in = {{(VALUE_WIDTH - IN_VALUE_W){1'b0}}, in_value};
    end
    if (CW > OUT_CNT_W) begin : g_sat
      assign cnt_sat  = (cnt_r  > CW'(OUT_CNT_MAX)) ? OUT_CNT_W'(OUT_CNT_MAX)
                                                    : cnt_r[OUT_CNT_W-1:0];
      assign size_sat = (fill_r > CW'(OUT_CNT_MAX)) ? OUT_CNT_W'(OUT_CNT_MAX)
                                                    : fill_r[OUT_CNT_W-1:0];
    end else begin : g_nosat
      assign cnt_sat  = OUT_CNT_W'(cnt_r);
      assign size_sat = OUT_CNT_W'(fill_r);
    end
  endgenerate

  assign has_room  = (fill_r < CW'(CAPACITY));
  assign issue_vld = cmd.scan && (scan_idx_r < fill_r);
  assign cmp_hit   = cmp_vld_r && (rdata_r == value_r);
  assign add_we    = cmd.exec && (func_r == FUNC_ADD) && has_room;

  assign sts.scan_done = (scan_idx_r >= fill_r) && !cmp_vld_r;
  assign sts.hit       = hit_r;
  assign sts.is_remove = (func_r == FUNC_REMOVE);

  // one write port: add at the fill position, or the swap on remove
  assign we    = add_we || cmd.move;
  assign waddr = cmd.move ? hit_idx_r : fill_r[AW-1:0];
  assign wdata = cmd.move ? rdata_r : value_r;
  assign raddr = cmd.rd_last ? AW'(fill_r - CW'(1)) : scan_idx_r[AW-1:0];

  assign out_ok          = res_ok_r;
  assign out_match_count = res_cnt_r;
  assign out_size        = res_size_r;
  assign out_empty_res   = res_empty_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    fill_nxt = fill_r;
    if (add_we) begin
      fill_nxt = fill_r + CW'(1);
    end else if (cmd.exec && (func_r == FUNC_CLEAR)) begin
      fill_nxt = '0;
    end else if (cmd.move) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      cmp_vld_r <= issue_vld;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_idx_r[AW-1:0];
    if (cmd.load) begin
      func_r     <= in_func;
      value_r    <= val_in;
      scan_idx_r <= '0;
      cnt_r      <= '0;
      hit_r      <= 1'b0;
      hit_idx_r  <= '0;
    end else begin
      if (issue_vld) begin
        scan_idx_r <= scan_idx_r + CW'(1);
      end
      if (cmp_hit) begin
        cnt_r <= cnt_r + CW'(1);
        if (!hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= cmp_idx_r;
        end
      end
      // hit_r doubles as the ok flag for add and clear
      if (cmd.exec && (((func_r == FUNC_ADD) && has_room) || (func_r == FUNC_CLEAR))) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_ok_r    <= (func_r == FUNC_COUNT) || hit_r;
      res_cnt_r   <= (func_r == FUNC_COUNT) ? cnt_sat : '0;
      res_size_r  <= size_sat;
      res_empty_r <= (fill_r == '0);
    end
  end

endmodule

// File: rtl/fixed_capacity_multiset_store_core.sv
// Top level of the fixed-capacity multiset store: controller plus datapath.
// Depends on fcms_pkg, fcms_ctrl and fcms_dp.
//
// Unordered multiset of up to CAPACITY entries (add, remove, count, contains,
// clear); one result beat per input beat. One item is processed at a time.
// Add, clear and unknown codes go through the execute and finish states. Remove,
// count and contains scan the live entries through the single read port of
// the entry memory, one entry per cycle; when a remove hits, the last entry
// is then read and moved into the hit slot. The result sits in an output
// register, so a stalled result only holds the next item back at its own
// result hand-off. No clearing pass after reset.
module fixed_capacity_multiset_store_core
  import fcms_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [IN_VALUE_W-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_ok,
  output logic [OUT_CNT_W-1:0]  out_match_count,
  output logic [OUT_CNT_W-1:0]  out_size,
  output logic                  out_empty_res
);

  fcms_cmd_t cmd;
  fcms_sts_t sts;

  fcms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  fcms_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_func         (in_func),
    .in_value        (in_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_ok          (out_ok),
    .out_match_count (out_match_count),
    .out_size        (out_size),
    .out_empty_res   (out_empty_res)
  );

endmodule

// File: rtl/fcms_checker.sv
// Port-level checker for the multiset store and its bind to the top level.
// Depends on fcms_pkg and fixed_capacity_multiset_store_core.
module fcms_checker
  import fcms_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_ok,
  input logic [OUT_CNT_W-1:0] out_match_count,
  input logic [OUT_CNT_W-1:0] out_size,
  input logic                 out_empty_res
);

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // input beats accepted whose result beat has not gone yet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok) && $stable(out_size)
      && $stable(out_match_count) && $stable(out_empty_res))
    else $error("stalled result beat changed");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result beat without a pending input beat");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_empty_res == (out_size == '0))
    else $error("empty flag disagrees with size");

  a_count_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_match_count <= out_size)
    else $error("match count exceeds size");

endmodule

bind fixed_capacity_multiset_store_core fcms_checker u_fcms_checker (.*);
